[design/toml_text_syntax_checker_top_assert.svh]
// assertion macros for the toml text syntax checker
// used by the port checker; needs clk and rst_n in scope
`ifndef TOML_TEXT_SYNTAX_CHECKER_TOP_ASSERT_SVH
`define TOML_TEXT_SYNTAX_CHECKER_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsc assertion failed");

// condition holds in the cycle after the trigger
`define TSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc assertion failed");

`endif

[design/tsc_pkg.sv]
// shared types and constants for the toml text syntax checker
// no dependencies; used by the top, front, queue and back modules
`timescale 1ns / 1ps

package tsc_pkg;

    // nesting limit and depth counter width
    localparam int MAX_NESTING = 255;
    localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);

    // front to back queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // byte codes that the checker reacts to
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_RBR    = 8'h5D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // classification of one byte
    typedef struct packed {
        logic quote;
        logic bslash;
        logic hash;
        logic lbr;
        logic rbr;
        logic nl;
        logic eq;
        logic ws;
        logic word;     // alphanumeric or underscore
    } byte_class_t;

    // one queued byte
    typedef struct packed {
        byte_class_t cls;
        logic        last;
    } q_entry_t;

    // checker state proper
    typedef struct packed {
        logic               string_mode;
        logic               comment_mode;
        logic               skip_following;
        logic [DEPTH_W-1:0] depth;
        logic               table_open;
        logic               line_start;
        logic               error_seen;
    } chk_state_t;

    localparam chk_state_t CHK_RESET = '{
        string_mode:    1'b0,
        comment_mode:   1'b0,
        skip_following: 1'b0,
        depth:          '0,
        table_open:     1'b0,
        line_start:     1'b1,
        error_seen:     1'b0
    };

endpackage

[design/toml_text_syntax_checker_top.sv]
// toml text syntax checker: one byte a cycle in, one verdict a text out,
// while the queue has room; the back end holds the queue once per text for
// the final check of the last byte, which has no lookahead.
// the verdict follows the last byte's transfer through the queue register,
// the lookahead register and the output register; stalls delay it.
// reset clears the queue, the syntax state and any pending verdict.
`timescale 1ns / 1ps

module toml_text_syntax_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid
);

    tsc_pkg::q_entry_t push_entry;
    tsc_pkg::q_entry_t head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_not_empty;

    // classify and accept
    tsc_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    // decoupling queue
    tsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    // syntax state and verdict
    tsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_valid    (is_valid)
    );

endmodule

[design/tsc_front.sv]
// front end: accepts text bytes and classifies them for the queue
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              push,
    output tsc_pkg::q_entry_t entry
);

    logic is_alpha;
    logic is_digit;

    // accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // character classes
    assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                      ((text_byte >= 8'h61) && (text_byte <= 8'h7A));

    always_comb
    begin
        entry.cls.quote  = (text_byte == tsc_pkg::CH_QUOTE);
        entry.cls.bslash = (text_byte == tsc_pkg::CH_BSLASH);
        entry.cls.hash   = (text_byte == tsc_pkg::CH_HASH);
        entry.cls.lbr    = (text_byte == tsc_pkg::CH_LBR);
        entry.cls.rbr    = (text_byte == tsc_pkg::CH_RBR);
        entry.cls.nl     = (text_byte == tsc_pkg::CH_NL);
        entry.cls.eq     = (text_byte == tsc_pkg::CH_EQ);
        entry.cls.ws     = (text_byte == tsc_pkg::CH_SPACE) ||
                           ((text_byte >= tsc_pkg::CH_TAB) && (text_byte <= tsc_pkg::CH_CR));
        entry.cls.word   = is_alpha || is_digit || (text_byte == tsc_pkg::CH_US);
        entry.last       = end_of_text;
    end

endmodule

[design/tsc_queue.sv]
// short queue of classified bytes between front and back
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsc_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output tsc_pkg::q_entry_t head
);

    tsc_pkg::q_entry_t              entry_reg [tsc_pkg::Q_DEPTH];
    logic [tsc_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tsc_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tsc_pkg::Q_CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == tsc_pkg::Q_CNT_W'(tsc_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tsc_pkg::Q_PTR_W'(tsc_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tsc_pkg::Q_PTR_W'(tsc_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[design/tsc_back.sv]
// back end: one byte of lookahead, syntax state update and verdict register
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  tsc_pkg::q_entry_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              is_valid
);

    tsc_pkg::chk_state_t  st_reg, st_next;
    tsc_pkg::byte_class_t held_reg, held_next;
    logic                 held_present_reg, held_present_next;
    logic                 prev_bs_reg, prev_bs_next;
    logic                 prev_ws_reg, prev_ws_next;
    logic                 finish_reg, finish_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 is_valid_reg, is_valid_next;
    tsc_pkg::chk_state_t  fin_state;
    logic                 slot_free;

    // state update for one held byte h, earlier byte flags and lookahead n
    function automatic tsc_pkg::chk_state_t check_byte(
        input tsc_pkg::chk_state_t  s,
        input tsc_pkg::byte_class_t h,
        input logic                 p_bs,
        input logic                 p_ws,
        input logic                 has_next,
        input tsc_pkg::byte_class_t n
    );
        tsc_pkg::chk_state_t r;
        logic                fail;
        r    = s;
        fail = 1'b0;
        if (s.error_seen)
        begin
            r = s;
        end
        else if (s.skip_following)
        begin
            r.skip_following = 1'b0;
        end
        else if (s.comment_mode)
        begin
            if (h.nl)
            begin
                r.comment_mode = 1'b0;
            end
        end
        else if (h.quote && !p_bs)
        begin
            r.string_mode = !s.string_mode;
        end
        else if (s.string_mode)
        begin
            r = s;
        end
        else if (h.hash)
        begin
            r.comment_mode = 1'b1;
            r.line_start   = 1'b1;
        end
        else
        begin
            // opening brackets
            if (h.lbr)
            begin
                if (has_next && n.lbr)
                begin
                    if (s.table_open || (s.depth != '0))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        r.skip_following = 1'b1;
                        r.table_open     = 1'b1;
                    end
                end
                else if (s.depth >= tsc_pkg::DEPTH_W'(tsc_pkg::MAX_NESTING))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    r.depth = s.depth + 1'b1;
                end
            end
            // closing brackets
            if (h.rbr)
            begin
                if (has_next && n.rbr)
                begin
                    if (!s.table_open)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        r.skip_following = 1'b1;
                        r.table_open     = 1'b0;
                    end
                end
                else if (s.depth == '0)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    r.depth = s.depth - 1'b1;
                end
            end
            // first significant byte of a line
            if (!fail && s.line_start && !h.ws && !h.lbr && !h.hash)
            begin
                if (!h.word)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    r.line_start = 1'b0;
                end
            end
            if (!fail)
            begin
                if (h.nl)
                begin
                    r.line_start = 1'b1;
                end
                // top-level equals sign needs whitespace both sides
                if (h.eq && (r.depth == '0) && !r.table_open)
                begin
                    if (!(p_ws && has_next && n.ws))
                    begin
                        fail = 1'b1;
                    end
                end
            end
            if (fail)
            begin
                r.error_seen = 1'b1;
            end
        end
        return r;
    endfunction

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = q_not_empty && !finish_reg;
    assign out_valid = out_valid_reg;
    assign is_valid  = is_valid_reg;

    // final check of the last byte, with no lookahead
    assign fin_state = check_byte(st_reg, held_reg, prev_bs_reg, prev_ws_reg, 1'b0,
                                  tsc_pkg::byte_class_t'('0));

    // next state
    always_comb
    begin
        st_next           = st_reg;
        held_next         = held_reg;
        held_present_next = held_present_reg;
        prev_bs_next      = prev_bs_reg;
        prev_ws_next      = prev_ws_reg;
        finish_next       = finish_reg;
        out_valid_next    = out_valid_reg;
        is_valid_next     = is_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // verdict transfer into the output register, then clear for next text
        if (finish_reg && slot_free)
        begin
            out_valid_next    = 1'b1;
            is_valid_next     = !fin_state.error_seen && !fin_state.string_mode &&
                                (fin_state.depth == '0) && !fin_state.table_open;
            st_next           = tsc_pkg::CHK_RESET;
            held_present_next = 1'b0;
            prev_bs_next      = 1'b0;
            prev_ws_next      = 1'b0;
            finish_next       = 1'b0;
        end

        // new byte from the queue: check the held one against it
        if (pop)
        begin
            if (held_present_reg)
            begin
                st_next      = check_byte(st_reg, held_reg, prev_bs_reg, prev_ws_reg, 1'b1,
                                          head.cls);
                prev_bs_next = held_reg.bslash;
                prev_ws_next = held_reg.ws;
            end
            held_next         = head.cls;
            held_present_next = 1'b1;
            finish_next       = head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= tsc_pkg::CHK_RESET;
            held_present_reg <= 1'b0;
            prev_bs_reg      <= 1'b0;
            prev_ws_reg      <= 1'b0;
            finish_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            st_reg           <= st_next;
            held_present_reg <= held_present_next;
            prev_bs_reg      <= prev_bs_next;
            prev_ws_reg      <= prev_ws_next;
            finish_reg       <= finish_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        is_valid_reg <= is_valid_next;
    end

endmodule

[design/tsc_checker.sv]
// port-level checker for the toml text syntax checker, bound to the top level
// depends on toml_text_syntax_checker_top_assert.svh
`timescale 1ns / 1ps
`include "toml_text_syntax_checker_top_assert.svh"

module tsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_text,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_valid
);

    logic [2:0] pending_reg, pending_next;
    logic       last_in;
    logic       res_out;

    // texts whose last byte has had its transfer but whose verdict has not
    assign last_in = in_valid && in_ready && end_of_text;
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + {2'b00, last_in} - {2'b00, res_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a verdict only follows a finished text
    `TSC_ASSERT_SAME(a_no_spurious_result, out_valid, pending_reg != 3'd0)

    // queue, lookahead and output register bound the texts in flight
    `TSC_ASSERT_SAME(a_pending_bound, 1'b1, pending_reg <= 3'd4)

    // a stalled verdict holds
    `TSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(is_valid))

endmodule

bind toml_text_syntax_checker_top tsc_checker u_tsc_checker (.*);
